FILE: rtl/bresenham_line_generator_defines.svh
// Assertion macros for the Bresenham line generator.
`ifndef BRESENHAM_LINE_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BLG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BLG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BLG_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BLG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/bresen_pkg.sv
// Shared types and constants for the Bresenham line generator.
`default_nettype none

package bresen_pkg;

    localparam int COORD_BITS = 10;
    localparam int CFG_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y = 1'b1;

    localparam logic [CFG_BITS-1:0] MAX_X_RESET = CFG_BITS'(176);
    localparam logic [CFG_BITS-1:0] MAX_Y_RESET = CFG_BITS'(220);

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] line_color_in;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  on_screen;
        logic                  line_end;
    } out_word_t;

    typedef struct packed {
        logic                       req_type;
        logic                       axes_swapped;
        logic                       minor_decrements;
        logic [COORD_BITS-1:0]      major_pos;
        logic [COORD_BITS-1:0]      major_end;
        logic [COORD_BITS-1:0]      minor_pos;
        logic [COORD_BITS-1:0]      major_delta;
        logic [COORD_BITS-1:0]      minor_delta;
        logic signed [ERR_BITS-1:0] error_term;
        logic [COLOR_BITS-1:0]      color;
    } setup_t;

    typedef struct packed {
        logic line_active;
    } walk_status_t;

endpackage

`default_nettype wire

FILE: rtl/bresen_setup.sv
// Input stage: registers a word and precomputes the line setup for a start request.
`default_nettype none

module bresen_setup
    import bresen_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          st_valid,
    input  wire logic     st_ready,
    output setup_t        st_word
);

    logic   valid_reg, valid_next;
    setup_t word_reg, word_next;

    logic [COORD_BITS-1:0] dx, dy, ma, na, mb, nb, m_lo, m_hi, n_lo, n_hi;
    logic                  steep;

    always_comb begin
        dx    = (s_data.x_start > s_data.x_end) ? s_data.x_start - s_data.x_end
                                                : s_data.x_end - s_data.x_start;
        dy    = (s_data.y_start > s_data.y_end) ? s_data.y_start - s_data.y_end
                                                : s_data.y_end - s_data.y_start;
        steep = dy > dx;
        if (steep) begin
            ma = s_data.y_start;
            na = s_data.x_start;
            mb = s_data.y_end;
            nb = s_data.x_end;
        end else begin
            ma = s_data.x_start;
            na = s_data.y_start;
            mb = s_data.x_end;
            nb = s_data.y_end;
        end
        if (ma > mb) begin
            m_lo = mb;
            m_hi = ma;
            n_lo = nb;
            n_hi = na;
        end else begin
            m_lo = ma;
            m_hi = mb;
            n_lo = na;
            n_hi = nb;
        end

        word_next.req_type         = s_data.req_type;
        word_next.axes_swapped     = steep;
        word_next.minor_decrements = !(n_lo < n_hi);
        word_next.major_pos        = m_lo;
        word_next.major_end        = m_hi;
        word_next.minor_pos        = n_lo;
        word_next.major_delta      = m_hi - m_lo;
        word_next.minor_delta      = (n_lo > n_hi) ? n_lo - n_hi : n_hi - n_lo;
        word_next.error_term       = {3'b000, word_next.major_delta[COORD_BITS-1:1]};
        word_next.color            = s_data.line_color_in;
    end

    assign s_ready  = !valid_reg || st_ready;
    assign st_valid = valid_reg;
    assign st_word  = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bresen_walk.sv
// Walk stage: holds line state; registers a pixel for each word except an idle step.
`default_nettype none

module bresen_walk
    import bresen_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                st_valid,
    output logic                     st_ready,
    input  wire setup_t              st_word,
    input  wire logic [CFG_BITS-1:0] max_x,
    input  wire logic [CFG_BITS-1:0] max_y,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data,
    output walk_status_t             status
);

    logic                       active_reg, active_next;
    logic                       swapped_reg, swapped_next;
    logic                       dec_reg, dec_next;
    logic [COORD_BITS-1:0]      major_reg, major_next;
    logic [COORD_BITS-1:0]      end_reg, end_next;
    logic [COORD_BITS-1:0]      minor_reg, minor_next;
    logic [COORD_BITS-1:0]      mdelta_reg, mdelta_next;
    logic [COORD_BITS-1:0]      ndelta_reg, ndelta_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [COLOR_BITS-1:0]      color_reg, color_next;
    logic                       m_valid_reg, m_valid_next;
    out_word_t                  out_reg, out_next;

    logic                       fire, is_start, emit, last;
    logic                       cur_swapped, cur_dec;
    logic [COORD_BITS-1:0]      cur_major, cur_end, cur_minor, cur_mdelta, cur_ndelta;
    logic signed [ERR_BITS-1:0] cur_err, err_sub;
    logic [COLOR_BITS-1:0]      cur_color;
    logic [COORD_BITS-1:0]      px, py;

    assign st_ready = !m_valid_reg || m_ready;
    assign fire     = st_valid && st_ready;
    assign is_start = st_word.req_type == REQ_START;
    assign emit     = is_start || active_reg;

    always_comb begin
        cur_swapped = is_start ? st_word.axes_swapped     : swapped_reg;
        cur_dec     = is_start ? st_word.minor_decrements : dec_reg;
        cur_major   = is_start ? st_word.major_pos        : major_reg;
        cur_end     = is_start ? st_word.major_end        : end_reg;
        cur_minor   = is_start ? st_word.minor_pos        : minor_reg;
        cur_mdelta  = is_start ? st_word.major_delta      : mdelta_reg;
        cur_ndelta  = is_start ? st_word.minor_delta      : ndelta_reg;
        cur_err     = is_start ? st_word.error_term       : err_reg;
        cur_color   = is_start ? st_word.color            : color_reg;

        px      = cur_swapped ? cur_minor : cur_major;
        py      = cur_swapped ? cur_major : cur_minor;
        last    = cur_major >= cur_end;
        err_sub = cur_err - signed'({2'b00, cur_ndelta});

        out_next.pixel_x     = px;
        out_next.pixel_y     = py;
        out_next.pixel_color = cur_color;
        out_next.on_screen   = ({1'b0, px} < max_x) && ({1'b0, py} < max_y);
        out_next.line_end    = last;

        active_next  = active_reg;
        swapped_next = swapped_reg;
        dec_next     = dec_reg;
        major_next   = major_reg;
        end_next     = end_reg;
        minor_next   = minor_reg;
        mdelta_next  = mdelta_reg;
        ndelta_next  = ndelta_reg;
        err_next     = err_reg;
        color_next   = color_reg;

        if (fire && emit) begin
            active_next  = !last;
            swapped_next = cur_swapped;
            dec_next     = cur_dec;
            end_next     = cur_end;
            mdelta_next  = cur_mdelta;
            ndelta_next  = cur_ndelta;
            color_next   = cur_color;
            major_next   = cur_major;
            minor_next   = cur_minor;
            err_next     = cur_err;
            if (!last) begin
                major_next = cur_major + COORD_BITS'(1);
                if (err_sub < 0) begin
                    minor_next = cur_dec ? cur_minor - COORD_BITS'(1)
                                         : cur_minor + COORD_BITS'(1);
                    err_next   = err_sub + signed'({2'b00, cur_mdelta});
                end else begin
                    err_next   = err_sub;
                end
            end
        end

        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        swapped_reg <= swapped_next;
        dec_reg     <= dec_next;
        major_reg   <= major_next;
        end_reg     <= end_next;
        minor_reg   <= minor_next;
        mdelta_reg  <= mdelta_next;
        ndelta_reg  <= ndelta_next;
        err_reg     <= err_next;
        color_reg   <= color_next;
        if (fire && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data             = out_reg;
    assign status.line_active = active_reg;

endmodule

`default_nettype wire

FILE: rtl/bresenham_line_generator.sv
// Top level of the Bresenham line generator: configuration registers and the two stages.
// A word is registered in the setup stage, and its result is then registered in the walk stage.
// Throughput: one word per cycle while m_ready is high; the walk state updates once per pixel.
// A step word while no line is active is consumed and gives no result.
// Reset is synchronous and active low: no line active, no result pending,
// max_x returns to 176 and max_y to 220.
`default_nettype none
`include "bresenham_line_generator_defines.svh"

module bresenham_line_generator
    import bresen_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire in_word_t                s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output out_word_t                    m_data
);

    logic [CFG_BITS-1:0] max_x_reg, max_x_next;
    logic [CFG_BITS-1:0] max_y_reg, max_y_next;
    logic                st_valid, st_ready;
    setup_t              st_word;
    walk_status_t        status;
    logic                idle_step;

    always_comb begin
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_X: max_x_next = cfg_wr_data;
                CFG_MAX_Y: max_y_next = cfg_wr_data;
                default: begin
                    max_x_next = max_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end else begin
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    bresen_setup u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st_word  (st_word)
    );

    bresen_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st_word  (st_word),
        .max_x    (max_x_reg),
        .max_y    (max_y_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .status   (status)
    );

    assign idle_step = st_valid && st_ready && st_word.req_type == REQ_STEP
                       && !status.line_active;

    // A pending last pixel means the line has finished; any other pixel means it goes on.
    `BLG_ASSERT_NOW(a_end_idle, aclk, aresetn, m_valid && m_data.line_end, !status.line_active)
    `BLG_ASSERT_NOW(a_mid_active, aclk, aresetn, m_valid && !m_data.line_end, status.line_active)
    `BLG_ASSERT_NEXT(a_idle_step, aclk, aresetn, idle_step, !m_valid)

endmodule

`default_nettype wire
